@@ design/rme_pkg.sv @@
// ----------------------------------------------------------------------------
// rme_pkg: shared types, constants and microprogram
// Datapath word types, control word layout and the sequencer program ROM
// for the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package rme_pkg;

    localparam int WIDTH = 16;
    localparam int CNT_W = $clog2(WIDTH + 1);
    localparam int PC_W  = 4;

    typedef logic [WIDTH-1:0] word_t;
    typedef logic [WIDTH:0]   wide_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [PC_W-1:0]  pc_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MODULUS  = 2'd0,
        REG_PUB_EXP  = 2'd1,
        REG_PRIV_EXP = 2'd2
    } reg_index_t;

    // step holds (stays at pc, no action) while this is true
    typedef enum logic [1:0] {
        H_NONE,
        H_NO_INPUT,
        H_MUL_BUSY,
        H_OUT_FULL
    } hold_t;

    // jump to target when true, else fall through
    typedef enum logic [2:0] {
        J_NEVER,
        J_ALWAYS,
        J_N_ZERO,
        J_E_LE1,
        J_E_ZERO,
        J_E_BIT0_CLR
    } jump_t;

    typedef enum logic [1:0] {
        SRC_VALUE,
        SRC_ACC,
        SRC_BASE,
        SRC_ONE
    } src_t;

    typedef enum logic [1:0] {
        D_NONE,
        D_BASE,
        D_ACC
    } dest_t;

    typedef enum logic [1:0] {
        O_NONE,
        O_ACC,
        O_BASE,
        O_ZERO
    } out_sel_t;

    typedef struct packed {
        hold_t    hold_c;
        jump_t    jump_c;
        pc_t      target;
        logic     load;
        logic     mstart;
        src_t     src_x;
        src_t     src_y;
        dest_t    dest;
        logic     e_shift;
        out_sel_t out_sel;
    } ctrl_t;

    typedef struct packed {
        logic no_input;
        logic n_zero;
        logic e_le1;
        logic e_zero;
        logic e_bit0_clr;
        logic mul_busy;
        logic out_full;
    } status_t;

    // program step addresses
    localparam pc_t ST_IDLE      = 4'd0;
    localparam pc_t ST_CHK_N     = 4'd1;
    localparam pc_t ST_RED_GO    = 4'd2;
    localparam pc_t ST_RED_WAIT  = 4'd3;
    localparam pc_t ST_CHK_E     = 4'd4;
    localparam pc_t ST_LOOP      = 4'd5;
    localparam pc_t ST_BIT       = 4'd6;
    localparam pc_t ST_MUL_GO    = 4'd7;
    localparam pc_t ST_MUL_WAIT  = 4'd8;
    localparam pc_t ST_SQR_GO    = 4'd9;
    localparam pc_t ST_SQR_WAIT  = 4'd10;
    localparam pc_t ST_OUT_ACC   = 4'd11;
    localparam pc_t ST_OUT_BASE  = 4'd12;
    localparam pc_t ST_OUT_ZERO  = 4'd13;

    function automatic ctrl_t ucode(input pc_t pc);
        ctrl_t cw;
        cw = '0;
        case (pc)
            ST_IDLE:
            begin
                cw.hold_c = H_NO_INPUT;
                cw.load   = 1'b1;
            end
            ST_CHK_N:
            begin
                cw.jump_c = J_N_ZERO;
                cw.target = ST_OUT_ZERO;
            end
            ST_RED_GO:
            begin
                cw.mstart = 1'b1;
                cw.src_x  = SRC_VALUE;
                cw.src_y  = SRC_ONE;
            end
            ST_RED_WAIT:
            begin
                cw.hold_c = H_MUL_BUSY;
                cw.dest   = D_BASE;
            end
            ST_CHK_E:
            begin
                cw.jump_c = J_E_LE1;
                cw.target = ST_OUT_BASE;
            end
            ST_LOOP:
            begin
                cw.jump_c = J_E_ZERO;
                cw.target = ST_OUT_ACC;
            end
            ST_BIT:
            begin
                cw.jump_c = J_E_BIT0_CLR;
                cw.target = ST_SQR_GO;
            end
            ST_MUL_GO:
            begin
                cw.mstart = 1'b1;
                cw.src_x  = SRC_ACC;
                cw.src_y  = SRC_BASE;
            end
            ST_MUL_WAIT:
            begin
                cw.hold_c = H_MUL_BUSY;
                cw.dest   = D_ACC;
            end
            ST_SQR_GO:
            begin
                cw.mstart = 1'b1;
                cw.src_x  = SRC_BASE;
                cw.src_y  = SRC_BASE;
            end
            ST_SQR_WAIT:
            begin
                cw.hold_c  = H_MUL_BUSY;
                cw.dest    = D_BASE;
                cw.e_shift = 1'b1;
                cw.jump_c  = J_ALWAYS;
                cw.target  = ST_LOOP;
            end
            ST_OUT_ACC:
            begin
                cw.hold_c  = H_OUT_FULL;
                cw.out_sel = O_ACC;
                cw.jump_c  = J_ALWAYS;
                cw.target  = ST_IDLE;
            end
            ST_OUT_BASE:
            begin
                cw.hold_c  = H_OUT_FULL;
                cw.out_sel = O_BASE;
                cw.jump_c  = J_ALWAYS;
                cw.target  = ST_IDLE;
            end
            ST_OUT_ZERO:
            begin
                cw.hold_c  = H_OUT_FULL;
                cw.out_sel = O_ZERO;
                cw.jump_c  = J_ALWAYS;
                cw.target  = ST_IDLE;
            end
            default:
            begin
                cw.jump_c = J_ALWAYS;
                cw.target = ST_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

@@ design/rme_modmul.sv @@
// ----------------------------------------------------------------------------
// rme_modmul: bit-serial modular multiplier
// Computes x * y mod n, one bit of x per cycle, MSB first, by
// double-and-add with a compare-subtract after each half step.
// ----------------------------------------------------------------------------
`default_nettype none

module rme_modmul (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire rme_pkg::word_t x,
    input  wire rme_pkg::word_t y,
    input  wire rme_pkg::word_t n,
    output logic               busy,
    output rme_pkg::word_t     prod
);

    rme_pkg::word_t x_reg, x_next;
    rme_pkg::word_t y_reg, y_next;
    rme_pkg::word_t p_reg, p_next;
    rme_pkg::cnt_t  cnt_reg, cnt_next;

    rme_pkg::wide_t n_ext, dbl, dbl_red, sum, sum_red;

    // y may equal n only when n is one; the sum then still stays below 2n
    always_comb
    begin
        n_ext   = {1'b0, n};
        dbl     = {p_reg, 1'b0};
        dbl_red = (dbl >= n_ext) ? (dbl - n_ext) : dbl;
        sum     = dbl_red + (x_reg[rme_pkg::WIDTH-1] ? {1'b0, y_reg} : '0);
        sum_red = (sum >= n_ext) ? (sum - n_ext) : sum;

        x_next   = x_reg;
        y_next   = y_reg;
        p_next   = p_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            x_next   = x;
            y_next   = y;
            p_next   = '0;
            cnt_next = rme_pkg::cnt_t'(rme_pkg::WIDTH);
        end
        else if (cnt_reg != '0)
        begin
            x_next   = {x_reg[rme_pkg::WIDTH-2:0], 1'b0};
            p_next   = sum_red[rme_pkg::WIDTH-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        p_reg <= p_next;
    end

    assign busy = (cnt_reg != '0);
    assign prod = p_reg;

endmodule

`default_nettype wire

@@ design/rme_seq.sv @@
// ----------------------------------------------------------------------------
// rme_seq: microprogram sequencer
// Step counter over the program ROM; holds a step while its hold
// condition is true and takes conditional jumps on datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

module rme_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rme_pkg::status_t st,
    output rme_pkg::ctrl_t        cw,
    output logic                  act
);

    rme_pkg::pc_t pc_reg, pc_next;
    logic         hold;
    logic         take;

    assign cw = rme_pkg::ucode(pc_reg);

    always_comb
    begin
        case (cw.hold_c)
            rme_pkg::H_NONE:     hold = 1'b0;
            rme_pkg::H_NO_INPUT: hold = st.no_input;
            rme_pkg::H_MUL_BUSY: hold = st.mul_busy;
            rme_pkg::H_OUT_FULL: hold = st.out_full;
            default:             hold = 1'b0;
        endcase

        case (cw.jump_c)
            rme_pkg::J_NEVER:      take = 1'b0;
            rme_pkg::J_ALWAYS:     take = 1'b1;
            rme_pkg::J_N_ZERO:     take = st.n_zero;
            rme_pkg::J_E_LE1:      take = st.e_le1;
            rme_pkg::J_E_ZERO:     take = st.e_zero;
            rme_pkg::J_E_BIT0_CLR: take = st.e_bit0_clr;
            default:               take = 1'b0;
        endcase

        if (hold)
            pc_next = pc_reg;
        else if (take)
            pc_next = cw.target;
        else
            pc_next = pc_reg + 1'b1;
    end

    assign act = !hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= rme_pkg::ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

@@ design/rsa_modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation: microcoded modular exponentiation
// Returns value^e mod modulus for e of at least 1, e picked by opcode from two config regs.
// ----------------------------------------------------------------------------
// One word at a time. An accepted value is first reduced mod the modulus
// (one pass of the modular multiplier), then raised to the public
// (opcode 0) or private (opcode 1) exponent by right-to-left
// square-and-multiply. Every modular multiply goes through a single
// bit-serial unit: a start step, then a wait step that holds while the
// unit is busy. Exponent 0 or 1 returns the reduced value, modulus 0
// returns 0. Each word also passes through the idle step. A finished
// result sits in an output register, so the next word is taken while it
// waits; the next output step holds until that register is free. Config
// writes are always ready and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_modular_exponentiation (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // config write channel
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [1:0]     cfg_index,
    input  wire rme_pkg::word_t cfg_data,
    // input word
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic           opcode,
    input  wire rme_pkg::word_t value,
    // result word
    output logic                out_valid,
    input  wire logic           out_stall,
    output rme_pkg::word_t      result
);

    // config registers
    rme_pkg::word_t n_reg, n_next;
    rme_pkg::word_t pub_reg, pub_next;
    rme_pkg::word_t priv_reg, priv_next;

    // working registers
    rme_pkg::word_t value_reg, value_next;
    rme_pkg::word_t e_reg, e_next;
    rme_pkg::word_t base_reg, base_next;
    rme_pkg::word_t acc_reg, acc_next;
    rme_pkg::word_t result_reg, result_next;
    logic           out_valid_reg, out_valid_next;

    rme_pkg::ctrl_t   cw;
    rme_pkg::status_t st;
    logic             act;
    logic             mul_start;
    logic             mul_busy;
    rme_pkg::word_t   mul_x, mul_y, mul_prod;

    rme_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cw    (cw),
        .act   (act)
    );

    rme_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .n     (n_reg),
        .busy  (mul_busy),
        .prod  (mul_prod)
    );

    function automatic rme_pkg::word_t pick(input rme_pkg::src_t s,
                                            input rme_pkg::word_t v,
                                            input rme_pkg::word_t a,
                                            input rme_pkg::word_t b);
        rme_pkg::word_t r;
        case (s)
            rme_pkg::SRC_VALUE: r = v;
            rme_pkg::SRC_ACC:   r = a;
            rme_pkg::SRC_BASE:  r = b;
            rme_pkg::SRC_ONE:   r = rme_pkg::word_t'(1);
            default:            r = '0;
        endcase
        return r;
    endfunction

    assign mul_start = act && cw.mstart;
    assign mul_x     = pick(cw.src_x, value_reg, acc_reg, base_reg);
    assign mul_y     = pick(cw.src_y, value_reg, acc_reg, base_reg);

    // status back to the sequencer
    always_comb
    begin
        st.no_input   = !in_valid;
        st.n_zero     = (n_reg == '0);
        st.e_le1      = (e_reg[rme_pkg::WIDTH-1:1] == '0);
        st.e_zero     = (e_reg == '0);
        st.e_bit0_clr = !e_reg[0];
        st.mul_busy   = mul_busy;
        st.out_full   = out_valid_reg && out_stall;
    end

    // only the idle step loads, so stall depends on the step alone
    assign in_stall  = !cw.load;
    assign cfg_ready = 1'b1;

    // config writes; index three is dropped
    always_comb
    begin
        n_next    = n_reg;
        pub_next  = pub_reg;
        priv_next = priv_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (rme_pkg::reg_index_t'(cfg_index))
                rme_pkg::REG_MODULUS:  n_next    = cfg_data;
                rme_pkg::REG_PUB_EXP:  pub_next  = cfg_data;
                rme_pkg::REG_PRIV_EXP: priv_next = cfg_data;
                default:               n_next    = n_reg;
            endcase
        end
    end

    // datapath
    always_comb
    begin
        value_next     = value_reg;
        e_next         = e_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (act)
        begin
            if (cw.load)
            begin
                value_next = value;
                e_next     = opcode ? priv_reg : pub_reg;
                // 1 mod n
                acc_next   = (n_reg == rme_pkg::word_t'(1)) ? '0 : rme_pkg::word_t'(1);
            end

            case (cw.dest)
                rme_pkg::D_NONE: ;
                rme_pkg::D_BASE: base_next = mul_prod;
                rme_pkg::D_ACC:  acc_next  = mul_prod;
                default: ;
            endcase

            if (cw.e_shift)
                e_next = {1'b0, e_reg[rme_pkg::WIDTH-1:1]};

            case (cw.out_sel)
                rme_pkg::O_NONE: ;
                rme_pkg::O_ACC:
                begin
                    result_next    = acc_reg;
                    out_valid_next = 1'b1;
                end
                rme_pkg::O_BASE:
                begin
                    result_next    = base_reg;
                    out_valid_next = 1'b1;
                end
                rme_pkg::O_ZERO:
                begin
                    result_next    = '0;
                    out_valid_next = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= rme_pkg::word_t'(2);
            pub_reg       <= '0;
            priv_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            n_reg         <= n_next;
            pub_reg       <= pub_next;
            priv_reg      <= priv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        e_reg      <= e_next;
        base_reg   <= base_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // multiplier must be quiet whenever the sequencer waits for a word
    a_idle_mul_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.hold_c == rme_pkg::H_NO_INPUT) |-> !mul_busy)
        else $error("modular multiplier busy while idle");

    // exponent register picks up the exponent chosen by opcode
    a_exp_select: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (e_reg == $past(opcode ? priv_reg : pub_reg)))
        else $error("wrong exponent loaded");

    // a result only appears from an output step
    a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cw.out_sel != rme_pkg::O_NONE))
        else $error("result valid without output step");

endmodule

`default_nettype wire
